>>> rtl/atw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atw_pkg: shared types and constants for the read timestamp watermark
// Table geometry, command and status codes, sequencer states and the
// request and response payload structs.
// ----------------------------------------------------------------------------
package atw_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int STAMP_WIDTH = 63;
   localparam int INDEX_WIDTH = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD        = 2'd0,
      CMD_REMOVE     = 2'd1,
      CMD_SET_COMMIT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_BELOW = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_SAT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [STAMP_WIDTH-1:0] stamp;
   } req_type;

   typedef struct packed {
      logic [STAMP_WIDTH-1:0] watermark;
      status_type             status;
      logic                   none_active;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/active_timestamp_watermark_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// active_timestamp_watermark_core: minimum active read timestamp tracker
// Keeps a table of active read timestamps with reference counts plus the
// latest commit timestamp, and answers every request with the watermark.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_*     in          req_valid / req_stall  atw_pkg::req_type (cmd, stamp)
//   rsp_*     out         rsp_valid / rsp_stall  atw_pkg::rsp_type
//
// Each request is accepted in ST_IDLE, then ST_SCAN walks the table entry by
// entry through the shared compare unit, and ST_FINISH commits the update
// and loads the response register.
// Reset clears the valid bits and counts at once, so no clearing pass is run.
// A held response stalls only the finish cycle; the next request may be
// accepted while the previous response still waits on rsp_stall.
//
module active_timestamp_watermark_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire atw_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      atw_pkg::rsp_type rsp_data
);

   // Table storage. Stamps are written only on allocation and read only
   // behind a valid bit, so they carry no reset.
   logic [atw_pkg::STAMP_WIDTH-1:0] entry_stamp_ff [atw_pkg::TABLE_DEPTH];
   logic [atw_pkg::COUNT_WIDTH-1:0] entry_count_ff [atw_pkg::TABLE_DEPTH];
   logic [atw_pkg::TABLE_DEPTH-1:0] entry_valid_ff;

   logic [atw_pkg::STAMP_WIDTH-1:0] commit_stamp_ff, commit_stamp_in;
   logic [atw_pkg::STAMP_WIDTH-1:0] min_stamp_ff, min_stamp_in;

   // Request held for the duration of the scan.
   atw_pkg::state_type              state_ff, state_in;
   atw_pkg::cmd_type                cmd_ff, cmd_in;
   logic [atw_pkg::STAMP_WIDTH-1:0] stamp_ff, stamp_in;
   logic                            below_ff, below_in;

   // Scan results.
   logic [atw_pkg::INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                            found_ff, found_in;
   logic [atw_pkg::INDEX_WIDTH-1:0] match_idx_ff, match_idx_in;
   logic [atw_pkg::COUNT_WIDTH-1:0] match_cnt_ff, match_cnt_in;
   logic                            free_ff, free_in;
   logic [atw_pkg::INDEX_WIDTH-1:0] free_idx_ff, free_idx_in;
   logic                            any_ff, any_in;
   logic [atw_pkg::STAMP_WIDTH-1:0] run_min_ff, run_min_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   atw_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   // Shared compare unit. During the scan its A operand is the current
   // entry; in the finish cycle it is the request stamp, so the same
   // less-than decides whether a new allocation lowers the minimum.
   logic [atw_pkg::STAMP_WIDTH-1:0] cmp_a;
   logic                            cmp_lt;
   logic                            cmp_eq;

   // Table write strobes from the finish cycle.
   logic                            cnt_we;
   logic [atw_pkg::INDEX_WIDTH-1:0] cnt_idx;
   logic [atw_pkg::COUNT_WIDTH-1:0] cnt_val;
   logic                            valid_set;
   logic                            valid_clr;
   logic                            stamp_we;

   logic                            req_accept;
   logic                            rsp_free;
   logic                            cur_valid;
   logic [atw_pkg::COUNT_WIDTH-1:0] cur_count;
   logic                            hit;
   logic                            keep_entry;
   logic                            alloc;
   logic                            any_fin;
   logic [atw_pkg::STAMP_WIDTH-1:0] min_fin;

   assign req_stall  = (state_ff != atw_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !(rsp_valid_ff && rsp_stall);

   assign cur_valid = entry_valid_ff[idx_ff];
   assign cur_count = entry_count_ff[idx_ff];
   assign cmp_a     = (state_ff == atw_pkg::ST_FINISH) ? stamp_ff : entry_stamp_ff[idx_ff];
   assign cmp_lt    = (cmp_a < run_min_ff);
   assign cmp_eq    = (cmp_a == stamp_ff);

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      stamp_in        = stamp_ff;
      below_in        = below_ff;
      idx_in          = idx_ff;
      found_in        = found_ff;
      match_idx_in    = match_idx_ff;
      match_cnt_in    = match_cnt_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      any_in          = any_ff;
      run_min_in      = run_min_ff;
      commit_stamp_in = commit_stamp_ff;
      min_stamp_in    = min_stamp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      cnt_we          = 1'b0;
      cnt_idx         = match_idx_ff;
      cnt_val         = match_cnt_ff;
      valid_set       = 1'b0;
      valid_clr       = 1'b0;
      stamp_we        = 1'b0;
      hit             = 1'b0;
      keep_entry      = 1'b0;
      alloc           = 1'b0;
      any_fin         = any_ff;
      min_fin         = run_min_ff;

      unique case (state_ff)
         atw_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_data.cmd;
               stamp_in = req_data.stamp;
               below_in = (req_data.stamp < commit_stamp_ff);
               idx_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               any_in   = 1'b0;
               state_in = atw_pkg::ST_SCAN;
            end
         end

         atw_pkg::ST_SCAN: begin
            hit = cur_valid && cmp_eq;
            // An entry that this remove will free does not count toward
            // the new minimum. Valid stamps are unique, so only one can hit.
            keep_entry = cur_valid &&
                         !(cmd_ff == atw_pkg::CMD_REMOVE && hit && cur_count <= 1);
            if (hit && !found_ff) begin
               found_in     = 1'b1;
               match_idx_in = idx_ff;
               match_cnt_in = cur_count;
            end
            if (!cur_valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            if (keep_entry && (!any_ff || cmp_lt)) begin
               any_in     = 1'b1;
               run_min_in = entry_stamp_ff[idx_ff];
            end
            if (idx_ff == atw_pkg::INDEX_WIDTH'(atw_pkg::TABLE_DEPTH - 1)) begin
               state_in = atw_pkg::ST_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         atw_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_data_in.status = atw_pkg::STATUS_OK;
               case (cmd_ff)
                  atw_pkg::CMD_ADD: begin
                     if (below_ff) begin
                        rsp_data_in.status = atw_pkg::STATUS_BELOW;
                     end else if (found_ff) begin
                        if (match_cnt_ff == atw_pkg::COUNT_MAX) begin
                           rsp_data_in.status = atw_pkg::STATUS_SAT;
                        end else begin
                           cnt_we  = 1'b1;
                           cnt_val = match_cnt_ff + 1'b1;
                        end
                     end else if (!free_ff) begin
                        rsp_data_in.status = atw_pkg::STATUS_FULL;
                     end else begin
                        alloc     = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_idx   = free_idx_ff;
                        cnt_val   = atw_pkg::COUNT_WIDTH'(1);
                        valid_set = 1'b1;
                        stamp_we  = 1'b1;
                     end
                  end
                  atw_pkg::CMD_REMOVE: begin
                     if (found_ff) begin
                        cnt_we = 1'b1;
                        if (match_cnt_ff <= 1) begin
                           cnt_val   = '0;
                           valid_clr = 1'b1;
                        end else begin
                           cnt_val = match_cnt_ff - 1'b1;
                        end
                     end
                  end
                  atw_pkg::CMD_SET_COMMIT: begin
                     commit_stamp_in = stamp_ff;
                  end
                  default: begin
                     // Unused command code: no change.
                  end
               endcase

               // Fold a newly allocated stamp into the scanned minimum.
               any_fin = any_ff || alloc;
               if (alloc && (!any_ff || cmp_lt)) begin
                  min_fin = stamp_ff;
               end
               if (any_fin) begin
                  min_stamp_in = min_fin;
               end

               rsp_data_in.none_active = !any_fin;
               if (any_fin) begin
                  rsp_data_in.watermark = min_fin;
               end else begin
                  rsp_data_in.watermark = commit_stamp_in;
               end
               rsp_valid_in = 1'b1;
               state_in     = atw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = atw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= atw_pkg::ST_IDLE;
         entry_valid_ff  <= '0;
         commit_stamp_ff <= '0;
         min_stamp_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < atw_pkg::TABLE_DEPTH; i++) begin
            entry_count_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         commit_stamp_ff <= commit_stamp_in;
         min_stamp_ff    <= min_stamp_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (cnt_we) begin
            entry_count_ff[cnt_idx] <= cnt_val;
         end
         if (valid_set) begin
            entry_valid_ff[free_idx_ff] <= 1'b1;
         end
         if (valid_clr) begin
            entry_valid_ff[match_idx_ff] <= 1'b0;
         end
      end
   end

   // Payload and scan registers carry no reset.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      stamp_ff     <= stamp_in;
      below_ff     <= below_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      match_idx_ff <= match_idx_in;
      match_cnt_ff <= match_cnt_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      any_ff       <= any_in;
      run_min_ff   <= run_min_in;
      rsp_data_ff  <= rsp_data_in;
      if (stamp_we) begin
         entry_stamp_ff[free_idx_ff] <= stamp_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> tb/sv/active_timestamp_watermark_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// active_timestamp_watermark_core_tb: self-checking bench for the watermark
// Drives add, remove, set-commit and unused requests into the core. A
// behavioral table model in the bench predicts every response, and each
// response is checked field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module active_timestamp_watermark_core_tb;
   import atw_pkg::*;

   // The watchdog limit covers the time that the core takes per request, the
   // longest receiver stall and the longest sender gap many times over.
   localparam int RESET_CYCLES     = 8;
   localparam int REQ_LATENCY      = TABLE_DEPTH + 2;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_PER_PHASE = 500;
   localparam int POOL_SIZE        = 24;

   // The command field has one code that the core does not use.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [STAMP_WIDTH-1:0] STAMP_MAX  = '1;
   localparam logic [STAMP_WIDTH-1:0] STAMP_EVEN = 63'h2AAA_AAAA_AAAA_AAAA;
   localparam logic [STAMP_WIDTH-1:0] STAMP_ODD  = 63'h5555_5555_5555_5555;

   // One row of directed stimulus. A row is sent reps times, with the stamp
   // moving by stride each time. When typed is set, the response is checked
   // against the values in the row rather than against the table model.
   typedef struct packed {
      logic [1:0]             cmd;
      logic [STAMP_WIDTH-1:0] stamp;
      int unsigned            reps;
      int unsigned            stride;
      bit                     typed;
      logic [STAMP_WIDTH-1:0] watermark;
      status_type             status;
      bit                     none_active;
   } stim_row_type;

   localparam int TABLE_ROWS = 21;

   stim_row_type stim_table [TABLE_ROWS] = '{
      // A remove of an absent stamp straight after reset.
      '{CMD_REMOVE,     63'd5,      1,       0, 1'b1, 63'd0,      STATUS_OK,    1'b1},
      '{CMD_ADD,        63'd0,      1,       0, 1'b1, 63'd0,      STATUS_OK,    1'b0},
      '{CMD_REMOVE,     63'd0,      1,       0, 1'b1, 63'd0,      STATUS_OK,    1'b1},
      '{CMD_SET_COMMIT, STAMP_MAX,  1,       0, 1'b1, STAMP_MAX,  STATUS_OK,    1'b1},
      // An add below the commit stamp is refused.
      '{CMD_ADD,        63'd100,    1,       0, 1'b1, STAMP_MAX,  STATUS_BELOW, 1'b1},
      '{CMD_ADD,        STAMP_MAX,  1,       0, 1'b1, STAMP_MAX,  STATUS_OK,    1'b0},
      '{CMD_UNUSED,     STAMP_EVEN, 1,       0, 1'b1, STAMP_MAX,  STATUS_OK,    1'b0},
      // Moving the commit stamp backwards is allowed.
      '{CMD_SET_COMMIT, 63'd1000,   1,       0, 1'b1, STAMP_MAX,  STATUS_OK,    1'b0},
      '{CMD_REMOVE,     STAMP_MAX,  1,       0, 1'b1, 63'd1000,   STATUS_OK,    1'b1},
      // Fill all sixteen entries, then try one more new stamp.
      '{CMD_ADD,        STAMP_ODD,  1,       0, 1'b0, 63'd0,      STATUS_OK,    1'b0},
      '{CMD_ADD,        63'd2000,   15,      1, 1'b0, 63'd0,      STATUS_OK,    1'b0},
      '{CMD_ADD,        63'd3000,   1,       0, 1'b1, 63'd2000,   STATUS_FULL,  1'b0},
      '{CMD_ADD,        63'd2007,   1,       0, 1'b0, 63'd0,      STATUS_OK,    1'b0},
      '{CMD_REMOVE,     63'd2000,   15,      1, 1'b0, 63'd0,      STATUS_OK,    1'b0},
      '{CMD_REMOVE,     63'd2007,   1,       0, 1'b0, 63'd0,      STATUS_OK,    1'b0},
      '{CMD_REMOVE,     STAMP_ODD,  1,       0, 1'b1, 63'd1000,   STATUS_OK,    1'b1},
      // Commit stamp set above an active stamp.
      '{CMD_ADD,        STAMP_EVEN, 1,       0, 1'b1, STAMP_EVEN, STATUS_OK,    1'b0},
      '{CMD_SET_COMMIT, STAMP_ODD,  1,       0, 1'b1, STAMP_EVEN, STATUS_OK,    1'b0},
      '{CMD_ADD,        63'd3,      1,       0, 1'b1, STAMP_EVEN, STATUS_BELOW, 1'b0},
      '{CMD_UNUSED,     STAMP_MAX,  1,       0, 1'b1, STAMP_EVEN, STATUS_OK,    1'b0},
      '{CMD_REMOVE,     STAMP_EVEN, 1,       0, 1'b1, STAMP_ODD,  STATUS_OK,    1'b1}
   };

   // Every input of the core has a known value from time zero.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Bench copy of the timestamp table and the commit stamp.
   logic [STAMP_WIDTH-1:0] model_stamp [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0] model_count [TABLE_DEPTH];
   logic                   model_valid [TABLE_DEPTH];
   logic [STAMP_WIDTH-1:0] model_commit;

   // Responses still owed by the core, oldest first.
   rsp_type watermark_queue [$];

   logic [STAMP_WIDTH-1:0] stamp_pool [POOL_SIZE];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int requests_sent = 0;
   int responses_got = 0;
   int idle_cycles   = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   active_timestamp_watermark_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted request to the bench table and returns the
   // response that the core must give for it. The minimum is taken over the
   // table after the update; an empty table reports the commit stamp.
   function automatic rsp_type predict_watermark(input req_type r);
      rsp_type                res;
      int                     hit;
      int                     slot;
      bit                     any;
      logic [STAMP_WIDTH-1:0] lowest;
      hit    = -1;
      slot   = -1;
      any    = 1'b0;
      lowest = '0;
      res.status = STATUS_OK;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (model_valid[i] && model_stamp[i] == r.stamp && hit < 0) hit = i;
         if (!model_valid[i] && slot < 0) slot = i;
      end
      case (r.cmd)
         CMD_ADD: begin
            if (r.stamp < model_commit) begin
               res.status = STATUS_BELOW;
            end else if (hit >= 0) begin
               if (model_count[hit] == COUNT_MAX) res.status = STATUS_SAT;
               else model_count[hit] = model_count[hit] + 1'b1;
            end else if (slot < 0) begin
               res.status = STATUS_FULL;
            end else begin
               model_stamp[slot] = r.stamp;
               model_count[slot] = COUNT_WIDTH'(1);
               model_valid[slot] = 1'b1;
            end
         end
         CMD_REMOVE: begin
            // A stamp that is not in the table is silently ignored.
            if (hit >= 0) begin
               if (model_count[hit] <= 1) begin
                  model_count[hit] = '0;
                  model_valid[hit] = 1'b0;
               end else begin
                  model_count[hit] = model_count[hit] - 1'b1;
               end
            end
         end
         CMD_SET_COMMIT: begin
            model_commit = r.stamp;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (model_valid[i] && (!any || model_stamp[i] < lowest)) begin
            lowest = model_stamp[i];
            any    = 1'b1;
         end
      end
      res.watermark   = any ? lowest : model_commit;
      res.none_active = !any;
      return res;
   endfunction

   function automatic logic [STAMP_WIDTH-1:0] random_stamp();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word[STAMP_WIDTH-1:0];
   endfunction

   // Presents one request from the falling edge, with random idle cycles in
   // front of it, and holds it until the core accepts it. Valid is left high
   // after acceptance; the next call or a drain decides whether it drops.
   task automatic issue_request(input req_type r, input bit use_typed,
                                input rsp_type typed_rsp);
      rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_watermark(r);
      watermark_queue.push_back(use_typed ? typed_rsp : predicted);
      requests_sent++;
   endtask

   // Holds the sender off until every outstanding response has arrived.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (watermark_queue.size() != 0) @(negedge clock);
   endtask

   // Walks rows first through last of the stimulus table.
   task automatic walk_table(input int first, input int last);
      req_type r;
      rsp_type t;
      for (int row = first; row <= last; row++) begin
         t.watermark   = stim_table[row].watermark;
         t.status      = stim_table[row].status;
         t.none_active = stim_table[row].none_active;
         for (int k = 0; k < int'(stim_table[row].reps); k++) begin
            r.cmd   = cmd_type'(stim_table[row].cmd);
            r.stamp = stim_table[row].stamp + STAMP_WIDTH'(k * stim_table[row].stride);
            issue_request(r, stim_table[row].typed, t);
         end
      end
   endtask

   // Empties the table with well-formed removes, so that a new phase starts
   // from a clean table.
   task automatic drain_table();
      req_type r;
      wait_for_drain();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         while (model_valid[i]) begin
            r.cmd   = CMD_REMOVE;
            r.stamp = model_stamp[i];
            issue_request(r, 1'b0, '0);
         end
      end
      wait_for_drain();
   endtask

   // Random traffic. Most stamps come from a small pool, so that adds hit
   // existing entries, removes find their stamps and the table fills up. A
   // few stamps are fully random noise. Half of the pool sits in a tight
   // cluster to exercise neighboring compares.
   task automatic run_random_phase(input int send_pct, input int recv_pct,
                                   input bit mid_pause);
      req_type r;
      int      roll;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < POOL_SIZE / 2) stamp_pool[i] = random_stamp();
         else stamp_pool[i] = stamp_pool[0] + STAMP_WIDTH'(i - POOL_SIZE / 2 + 1);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         if (mid_pause && n == RANDOM_PER_PHASE / 2) wait_for_drain();
         roll = $urandom_range(0, 99);
         if (roll < 45) r.cmd = CMD_ADD;
         else if (roll < 85) r.cmd = CMD_REMOVE;
         else if (roll < 95) r.cmd = CMD_SET_COMMIT;
         else r.cmd = cmd_type'(CMD_UNUSED);
         case (r.cmd)
            CMD_ADD, CMD_REMOVE: begin
               if ($urandom_range(0, 9) == 0) r.stamp = random_stamp();
               else r.stamp = stamp_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            CMD_SET_COMMIT: begin
               // Mostly a pool stamp, so that later adds land on both
               // sides of the commit stamp; sometimes back to zero.
               roll = $urandom_range(0, 3);
               if (roll == 0) r.stamp = '0;
               else if (roll == 1) r.stamp = random_stamp();
               else r.stamp = stamp_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            default: begin
               r.stamp = random_stamp();
            end
         endcase
         issue_request(r, 1'b0, '0);
      end
      drain_table();
   endtask

   // The receiver decides its stall for the next edge at each falling edge.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Every accepted response is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_got++;
         status_seen[rsp_data.status]++;
         if (watermark_queue.size() == 0) begin
            $error("response with no request outstanding: watermark %h",
                   rsp_data.watermark);
            mismatches++;
         end else begin
            want = watermark_queue.pop_front();
            if (rsp_data.watermark !== want.watermark) begin
               $error("watermark: expected %h, got %h", want.watermark,
                      rsp_data.watermark);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.none_active !== want.none_active) begin
               $error("none_active: expected %0d, got %0d", want.none_active,
                      rsp_data.none_active);
               mismatches++;
            end
         end
      end
   end

   // The watchdog counts cycles in which neither channel moves a request or
   // a response, and ends the run when the core appears to hang.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         model_stamp[i] = '0;
         model_count[i] = '0;
         model_valid[i] = 1'b0;
      end
      model_commit = '0;

      // Synchronous reset, held for RESET_CYCLES and released on a falling edge
      // so that the first request sees a settled core.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows run without idling on either side.
      walk_table(0, TABLE_ROWS - 1);
      drain_table();

      // Random traffic under three idling patterns. The first phase also
      // pauses the sender halfway until the core has answered everything.
      run_random_phase(17, 54, 1'b1);
      run_random_phase(54, 17, 1'b0);
      run_random_phase(0, 0, 1'b0);

      wait_for_drain();
      repeat (2 * REQ_LATENCY) @(posedge clock);

      $display("Covered %0d requests and %0d responses: directed rows and three",
               requests_sent, responses_got);
      $display("idling phases; status ok %0d, below %0d, full %0d, sat %0d.",
               status_seen[STATUS_OK], status_seen[STATUS_BELOW],
               status_seen[STATUS_FULL], status_seen[STATUS_SAT]);
      if (mismatches == 0 && watermark_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> active_timestamp_watermark_core.f
rtl/atw_pkg.sv
rtl/active_timestamp_watermark_core.sv
tb/sv/active_timestamp_watermark_core_tb.sv
